// ----- design/afrp_pkg.sv -----
// Package with frame offsets and the result type of the API receive frame parser.
package afrp_pkg;

	localparam logic [7:0] START_DELIM     = 8'h7E;
	localparam logic [7:0] SUM_BASE        = 8'hFF;

	localparam logic [4:0] OFS_TYPE        = 5'd3;
	localparam logic [4:0] OFS_LONG_FIRST  = 5'd4;
	localparam logic [4:0] OFS_LONG_LAST   = 5'd11;
	localparam logic [4:0] OFS_SHORT_FIRST = 5'd12;
	localparam logic [4:0] OFS_SHORT_LAST  = 5'd13;
	localparam logic [4:0] OFS_OPTIONS     = 5'd14;
	localparam logic [4:0] OFS_MSG         = 5'd15;
	localparam logic [4:0] OFS_DEST_LAST   = 5'd16;
	localparam logic [4:0] OFS_SRC_FIRST   = 5'd17;
	localparam logic [4:0] OFS_SRC_LAST    = 5'd18;
	localparam logic [4:0] OFS_KIND        = 5'd19;
	localparam logic [4:0] OFS_COMMAND     = 5'd20;
	localparam logic [4:0] OFS_STAT_HIGH   = 5'd21;
	localparam logic [4:0] OFS_STAT_LOW    = 5'd22;
	localparam logic [4:0] OFS_STAT_VALUE  = 5'd23;
	localparam logic [4:0] OFS_MSG_SUM     = 5'd26;
	localparam logic [4:0] OFS_FRAME_SUM   = 5'd27;

	typedef struct packed {
		logic [63:0] source_long_address;
		logic [15:0] source_short_address;
		logic [7:0]  receive_options;
		logic [15:0] message_destination;
		logic [15:0] message_source;
		logic [7:0]  message_kind;
		logic [7:0]  message_command;
		logic [7:0]  status_high;
		logic [7:0]  status_low;
		logic [7:0]  status_value;
		logic        frame_sum_ok;
		logic        message_sum_ok;
	} afrp_result_t;

endpackage

// ----- design/afrp_core.sv -----
// Frame tracking, field capture and checksum logic of the API receive frame parser.
module afrp_core
	import afrp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   rx_byte,
	output logic         last,
	output afrp_result_t result
);

	logic        in_frame_q;
	logic [4:0]  ofs_q;
	logic [7:0]  frame_sum_q;
	logic [7:0]  message_sum_q;
	logic        message_sum_match_q;
	logic [63:0] long_address_q;
	logic [15:0] short_address_q;
	logic [7:0]  options_q;
	logic [15:0] destination_q;
	logic [15:0] source_q;
	logic [7:0]  kind_q;
	logic [7:0]  command_q;
	logic [7:0]  status_high_q;
	logic [7:0]  status_low_q;
	logic [7:0]  status_value_q;

	assign last = in_frame_q && (ofs_q == OFS_FRAME_SUM);

	always_comb begin
		result.source_long_address  = long_address_q;
		result.source_short_address = short_address_q;
		result.receive_options      = options_q;
		result.message_destination  = destination_q;
		result.message_source       = source_q;
		result.message_kind         = kind_q;
		result.message_command      = command_q;
		result.status_high          = status_high_q;
		result.status_low           = status_low_q;
		result.status_value         = status_value_q;
		result.frame_sum_ok         = (rx_byte == (SUM_BASE - frame_sum_q));
		result.message_sum_ok       = message_sum_match_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q          <= 1'b0;
			ofs_q               <= '0;
			frame_sum_q         <= '0;
			message_sum_q       <= '0;
			message_sum_match_q <= 1'b0;
		end else if (step) begin
			if (!in_frame_q) begin
				if (rx_byte == START_DELIM) begin
					in_frame_q  <= 1'b1;
					frame_sum_q <= '0;
					ofs_q       <= 5'd1;
				end else begin
					ofs_q <= '0;
				end
			end else begin
				ofs_q <= ofs_q + 5'd1;
				if (ofs_q >= OFS_TYPE && ofs_q < OFS_FRAME_SUM) begin
					frame_sum_q <= frame_sum_q + rx_byte;
				end
				if (ofs_q == OFS_MSG) begin
					message_sum_q <= rx_byte;
				end else if (ofs_q > OFS_MSG && ofs_q < OFS_MSG_SUM) begin
					message_sum_q <= message_sum_q + rx_byte;
				end
				if (ofs_q == OFS_MSG_SUM) begin
					message_sum_match_q <= (rx_byte == (SUM_BASE - message_sum_q));
				end
				if (ofs_q == OFS_FRAME_SUM) begin
					in_frame_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && in_frame_q) begin
			case (ofs_q) inside
				[OFS_LONG_FIRST:OFS_LONG_LAST]: begin
					long_address_q <= {long_address_q[55:0], rx_byte};
				end
				[OFS_SHORT_FIRST:OFS_SHORT_LAST]: begin
					short_address_q <= {short_address_q[7:0], rx_byte};
				end
				OFS_OPTIONS: begin
					options_q <= rx_byte;
				end
				[OFS_MSG:OFS_DEST_LAST]: begin
					destination_q <= {destination_q[7:0], rx_byte};
				end
				[OFS_SRC_FIRST:OFS_SRC_LAST]: begin
					source_q <= {source_q[7:0], rx_byte};
				end
				OFS_KIND: begin
					kind_q <= rx_byte;
				end
				OFS_COMMAND: begin
					command_q <= rx_byte;
				end
				OFS_STAT_HIGH: begin
					status_high_q <= rx_byte;
				end
				OFS_STAT_LOW: begin
					status_low_q <= rx_byte;
				end
				OFS_STAT_VALUE: begin
					status_value_q <= rx_byte;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- design/api_frame_receive_parser.sv -----
// Top level of the API receive frame parser: input register, parse core, result register.
// Accepts one received byte per transfer and, on the checksum byte of a 28-byte receive
// frame that opens with 0x7E, delivers one result carrying the captured addresses,
// options, message fields and two checksum flags; bytes outside a frame produce nothing.
// A byte is taken in every cycle unless a stalled checksum byte holds the input register;
// it waits in the input register until the parse core updates its state, and a result
// appears in the output register the cycle after the checksum byte is processed. Only a
// result still held in the output register stalls a checksum byte behind it.
module api_frame_receive_parser
	import afrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] source_long_address,
	output logic [15:0] source_short_address,
	output logic [7:0]  receive_options,
	output logic [15:0] message_destination,
	output logic [15:0] message_source,
	output logic [7:0]  message_kind,
	output logic [7:0]  message_command,
	output logic [7:0]  status_high,
	output logic [7:0]  status_low,
	output logic [7:0]  status_value,
	output logic        frame_sum_ok,
	output logic        message_sum_ok
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         advance_s1;
	logic         last;
	afrp_result_t result;
	logic         out_valid_q;
	afrp_result_t res_q;

	assign advance_s1 = valid_s1 && (!last || !out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	afrp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance_s1),
		.rx_byte (byte_s1),
		.last    (last),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last) begin
			res_q <= result;
		end
	end

	assign out_valid            = out_valid_q;
	assign source_long_address  = res_q.source_long_address;
	assign source_short_address = res_q.source_short_address;
	assign receive_options      = res_q.receive_options;
	assign message_destination  = res_q.message_destination;
	assign message_source       = res_q.message_source;
	assign message_kind         = res_q.message_kind;
	assign message_command      = res_q.message_command;
	assign status_high          = res_q.status_high;
	assign status_low           = res_q.status_low;
	assign status_value         = res_q.status_value;
	assign frame_sum_ok         = res_q.frame_sum_ok;
	assign message_sum_ok       = res_q.message_sum_ok;

endmodule
